// ===== design/vdp_pkg.sv =====
`default_nettype none

package vdp_pkg;

   // Address widths of the two attached memories.
   localparam int VRAM_ADDR_W = 14;
   localparam int CRAM_ADDR_W = 6;

   // Request kinds carried on the request side-band.
   localparam logic [2:0] REQ_DATA_READ  = 3'd0;
   localparam logic [2:0] REQ_DATA_WRITE = 3'd1;
   localparam logic [2:0] REQ_STATUS     = 3'd2;
   localparam logic [2:0] REQ_CONTROL    = 3'd3;
   localparam logic [2:0] REQ_TICK       = 3'd4;
   localparam logic [2:0] REQ_VCOUNT     = 3'd5;

   // Line timing.
   localparam logic [8:0] LINE_LAST   = 9'd261;
   localparam logic [8:0] LINE_VBLANK = 9'd192;

   // Register file index of the configuration register.
   localparam logic CSR_HANDHELD_IDX = 1'b0;

   // Mode register values after reset.
   localparam logic [7:0] REG_INIT [16] = '{
      8'h36, 8'ha0, 8'hff, 8'hff, 8'hff, 8'hff, 8'hfb, 8'h00,
      8'h00, 8'h00, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   // Access to the video memory.
   typedef struct packed {
      logic                   we;
      logic                   re;
      logic [VRAM_ADDR_W-1:0] addr;
      logic [7:0]             wdata;
   } vram_req_type;

   // Access to the palette memory.
   typedef struct packed {
      logic                   we;
      logic                   re;
      logic [CRAM_ADDR_W-1:0] addr;
      logic [7:0]             wdata;
   } cram_req_type;

   // Result of one request before the palette read data is merged in.
   typedef struct packed {
      logic [7:0] value;
      logic       from_cram;
      logic       irq;
   } rsp_type;

endpackage

`default_nettype wire

// ===== design/vdp_ram.sv =====
`default_nettype none

module vdp_ram #(
   parameter int ADDR_W = 6,
   parameter int DATA_W = 8
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [DATA_W-1:0] wdata,
   output logic      [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [2**ADDR_W];

   // Single port; read data is registered and holds until the next read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata <= mem[addr];
      end
   end

endmodule

`default_nettype wire

// ===== design/vdp_core.sv =====
`default_nettype none

module vdp_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic [2:0]            req_type,
   input  wire logic [7:0]            data_byte,
   input  wire logic                  handheld,
   input  wire logic [7:0]            vram_q,
   output vdp_pkg::vram_req_type      vram_req,
   output vdp_pkg::cram_req_type      cram_req,
   output vdp_pkg::rsp_type           rsp_in
);

   logic [14:0] addr_ff, addr_in;
   logic [7:0]  latch_ff, latch_in;
   logic        second_ff, second_in;
   logic [7:0]  prefetch_ff, prefetch_in;
   logic        pf_mem_ff, pf_mem_in;
   logic [1:0]  status_ff, status_in;
   logic [8:0]  line_ff, line_in;
   logic [7:0]  countdown_ff, countdown_in;
   logic [7:0]  regs_ff [16];
   logic [7:0]  regs_in [16];

   logic [7:0]  pf_cur;
   logic [5:0]  pal_mask;
   logic [5:0]  pal_idx;
   logic [14:0] pal_next;
   logic [14:0] vram_next;
   logic [13:0] ctrl_addr;
   logic [8:0]  line_inc;

   // The prefetch byte lives in the video memory read register right after a fetch.
   assign pf_cur    = pf_mem_ff ? vram_q : prefetch_ff;
   assign pal_mask  = {handheld, 5'h1f};
   assign pal_idx   = addr_ff[5:0] & pal_mask;
   assign pal_next  = {1'b1, 8'h00, (addr_ff[5:0] + 6'd1) & pal_mask};
   assign vram_next = {1'b0, addr_ff[13:0] + 14'd1};
   assign ctrl_addr = {data_byte[5:0], latch_ff};
   assign line_inc  = line_ff + 9'd1;

   // Next state and memory accesses for the request at the head of the pipe.
   always_comb begin
      addr_in      = addr_ff;
      latch_in     = latch_ff;
      second_in    = second_ff;
      prefetch_in  = prefetch_ff;
      pf_mem_in    = pf_mem_ff;
      status_in    = status_ff;
      line_in      = line_ff;
      countdown_in = countdown_ff;
      regs_in      = regs_ff;
      vram_req     = '0;
      cram_req     = '0;
      rsp_in       = '0;

      case (req_type)
         vdp_pkg::REQ_DATA_READ: begin
            if (addr_ff[14]) begin
               cram_req.re      = advance;
               cram_req.addr    = pal_idx;
               rsp_in.from_cram = 1'b1;
               addr_in          = pal_next;
            end else begin
               rsp_in.value  = pf_cur;
               vram_req.re   = advance;
               vram_req.addr = addr_ff[13:0];
               pf_mem_in     = 1'b1;
               addr_in       = vram_next;
            end
            second_in = 1'b0;
         end
         vdp_pkg::REQ_DATA_WRITE: begin
            if (addr_ff[14]) begin
               cram_req.we    = advance;
               cram_req.addr  = pal_idx;
               cram_req.wdata = data_byte;
               addr_in        = pal_next;
            end else begin
               prefetch_in    = data_byte;
               pf_mem_in      = 1'b0;
               vram_req.we    = advance;
               vram_req.addr  = addr_ff[13:0];
               vram_req.wdata = data_byte;
               addr_in        = vram_next;
            end
            second_in = 1'b0;
         end
         vdp_pkg::REQ_STATUS: begin
            rsp_in.value = {status_ff, 6'b000000};
            status_in    = 2'b00;
            second_in    = 1'b0;
         end
         vdp_pkg::REQ_CONTROL: begin
            if (!second_ff) begin
               latch_in  = data_byte;
               second_in = 1'b1;
            end else begin
               if (data_byte[7]) begin
                  if (data_byte[6]) begin
                     addr_in = {1'b1, 8'h00, latch_ff[5:0] & pal_mask};
                  end else begin
                     regs_in[data_byte[3:0]] = latch_ff;
                  end
               end else if (data_byte[6]) begin
                  addr_in = {1'b0, ctrl_addr};
               end else begin
                  // Set the address, fetch the byte there and step past it.
                  vram_req.re   = advance;
                  vram_req.addr = ctrl_addr;
                  pf_mem_in     = 1'b1;
                  addr_in       = {1'b0, ctrl_addr + 14'd1};
               end
               second_in = 1'b0;
            end
         end
         vdp_pkg::REQ_TICK: begin
            if (line_ff == vdp_pkg::LINE_VBLANK) begin
               status_in[1] = 1'b1;
            end
            if (line_ff == vdp_pkg::LINE_LAST) begin
               line_in      = '0;
               countdown_in = regs_ff[10];
            end else begin
               line_in = line_inc;
               if (line_inc < vdp_pkg::LINE_VBLANK) begin
                  if (countdown_ff == 8'd0) begin
                     status_in[0] = 1'b1;
                     countdown_in = regs_ff[10];
                  end else begin
                     countdown_in = countdown_ff - 8'd1;
                  end
               end
            end
         end
         vdp_pkg::REQ_VCOUNT: begin
            rsp_in.value = (line_ff < vdp_pkg::LINE_VBLANK) ? line_ff[7:0] : 8'hff;
         end
         default: begin
         end
      endcase

      rsp_in.irq = (status_in[1] & regs_in[1][5]) | (status_in[0] & regs_in[0][4]);
   end

   // State registers step once per request.
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= '0;
         latch_ff     <= '0;
         second_ff    <= 1'b0;
         prefetch_ff  <= '0;
         pf_mem_ff    <= 1'b0;
         status_ff    <= '0;
         line_ff      <= '0;
         countdown_ff <= 8'hff;
         regs_ff      <= vdp_pkg::REG_INIT;
      end else if (advance) begin
         addr_ff      <= addr_in;
         latch_ff     <= latch_in;
         second_ff    <= second_in;
         prefetch_ff  <= prefetch_in;
         pf_mem_ff    <= pf_mem_in;
         status_ff    <= status_in;
         line_ff      <= line_in;
         countdown_ff <= countdown_in;
         regs_ff      <= regs_in;
      end
   end

`ifndef SYNTHESIS
   a_line_range: assert property (@(posedge clock) disable iff (reset)
      line_ff <= vdp_pkg::LINE_LAST)
      else $error("line counter beyond last line");
   a_pal_addr_form: assert property (@(posedge clock) disable iff (reset)
      addr_ff[14] |-> (addr_ff[13:6] == 8'h00))
      else $error("palette address has high bits set");
   a_vram_one_op: assert property (@(posedge clock) disable iff (reset)
      !(vram_req.we && vram_req.re))
      else $error("video memory read and write together");
   a_mem_idle: assert property (@(posedge clock) disable iff (reset)
      !advance |-> !(vram_req.we || vram_req.re || cram_req.we || cram_req.re))
      else $error("memory access without a request");
   a_fetch_marks: assert property (@(posedge clock) disable iff (reset)
      (advance && vram_req.re) |=> pf_mem_ff)
      else $error("fetch did not mark the prefetch source");
`endif

endmodule

`default_nettype wire

// ===== design/vdp_port_and_line_timing_top.sv =====
// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready  tuser: req_type; tdata: data_byte
// rsp       out        rsp_tvalid/rsp_tready  tdata: read_data, irq
// csr       in         APB psel/penable       register 0: handheld_mode
//
// One request is taken per clock cycle when the result side keeps up.
// A request is held in the input register and is then processed into
// the result register, from which its response is taken.
// The single-port video and palette memories are touched at most once per request.
// Reset is synchronous; no memory clearing pass is needed.
// A stalled result holds while one more request waits in the input register.
`default_nettype none

module vdp_port_and_line_timing_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic [2:0]  req_tuser,   // [2:0] req_type
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] read_data, [8] irq
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic                  handheld_ff;
   logic                  in_valid_ff;
   logic [2:0]            in_type_ff;
   logic [7:0]            in_data_ff;
   logic                  rsp_valid_ff;
   vdp_pkg::rsp_type      rsp_ff;
   vdp_pkg::rsp_type      rsp_in;
   vdp_pkg::vram_req_type vram_req;
   vdp_pkg::cram_req_type cram_req;
   logic [7:0]            vram_q;
   logic [7:0]            cram_q;
   logic                  advance;

   // Configuration register.
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == vdp_pkg::CSR_HANDHELD_IDX) ?
                       {31'd0, handheld_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         handheld_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr[2] == vdp_pkg::CSR_HANDHELD_IDX) begin
         handheld_ff <= csr_pwdata[0];
      end
   end

   // Pipeline control: the head request moves on when the result slot frees.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_type_ff <= req_tuser;
         in_data_ff <= req_tdata;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   vdp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .req_type  (in_type_ff),
      .data_byte (in_data_ff),
      .handheld  (handheld_ff),
      .vram_q    (vram_q),
      .vram_req  (vram_req),
      .cram_req  (cram_req),
      .rsp_in    (rsp_in)
   );

   vdp_ram #(
      .ADDR_W (vdp_pkg::VRAM_ADDR_W),
      .DATA_W (8)
   ) u_vram (
      .clock (clock),
      .we    (vram_req.we),
      .re    (vram_req.re),
      .addr  (vram_req.addr),
      .wdata (vram_req.wdata),
      .rdata (vram_q)
   );

   vdp_ram #(
      .ADDR_W (vdp_pkg::CRAM_ADDR_W),
      .DATA_W (8)
   ) u_cram (
      .clock (clock),
      .we    (cram_req.we),
      .re    (cram_req.re),
      .addr  (cram_req.addr),
      .wdata (cram_req.wdata),
      .rdata (cram_q)
   );

   // Palette reads land in the palette read register alongside the result.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff.irq, rsp_ff.from_cram ? cram_q : rsp_ff.value};

endmodule

`default_nettype wire
